/* hw/rtl/cws_pkg.sv */
`timescale 1ns / 1ps

package cws_pkg;

   // Width of the spindle turn counter that wraps
   localparam int TURN_COUNT_BITS = 20;
   localparam logic [19:0] TURN_MASK =
      (TURN_COUNT_BITS >= 20) ? 20'hFFFFF : 20'((64'd1 << TURN_COUNT_BITS) - 64'd1);

   // Feed = pitch * speed * 2 / 60 = pitch * speed / 30, by reciprocal:
   // floor(x / 30) == (x * RECIP) >> SHIFT for every x below 2^30
   localparam logic [30:0] FEED_RECIP = 31'd1145324613;
   localparam int          FEED_SHIFT = 35;

   // Register indexes
   localparam logic [2:0] REG_WIRE_PITCH    = 3'd0;
   localparam logic [2:0] REG_BOBBIN_WIDTH  = 3'd1;
   localparam logic [2:0] REG_TURN_LIMIT    = 3'd2;
   localparam logic [2:0] REG_TURNS_LAYER   = 3'd3;
   localparam logic [2:0] REG_LAYER_STEP    = 3'd4;
   localparam logic [2:0] REG_SPIN_DIR      = 3'd5;
   localparam logic [2:0] REG_TRAVERSE_FEED = 3'd6;
   localparam logic [2:0] REG_RADIAL_FEED   = 3'd7;

   // Spindle direction codes
   localparam logic [1:0] DIR_CW  = 2'd1;
   localparam logic [1:0] DIR_CCW = 2'd2;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_START     = 3'd1,
      OP_PAUSE     = 3'd2,
      OP_RESUME    = 3'd3,
      OP_ABORT     = 3'd4,
      OP_SET_SPEED = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_WIND  = 2'd1,
      MODE_PAUSE = 2'd2,
      MODE_DONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      SP_NONE     = 3'd0,
      SP_SET_RPM  = 3'd1,
      SP_RPM_ZERO = 3'd2,
      SP_STOP     = 3'd3,
      SP_RESTART  = 3'd4
   } spindle_cmd_type;

   typedef enum logic [1:0] {
      AX_NONE = 2'd0,
      AX_MOVE = 2'd1,
      AX_STOP = 2'd2
   } axis_cmd_type;

   typedef struct packed {
      logic [15:0] wire_pitch_um;
      logic [19:0] bobbin_width_um;
      logic [19:0] turn_limit;
      logic [15:0] turns_per_layer;
      logic [15:0] layer_step_um;
      logic        spin_cw;
      logic [19:0] traverse_max_feed;
      logic [19:0] radial_feed;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [19:0] prev_turn;
      logic [19:0] layer_turns;
      logic [15:0] layer_count;
      logic        moving_forward;
      logic [19:0] turn_latch;
      logic [13:0] speed_setting;
   } state_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [19:0]        turn_count;
      logic signed [23:0] trav_meas;
      logic signed [23:0] radial_pos;
      logic [13:0]        new_speed;
   } item_type;

   typedef struct packed {
      logic [1:0]         run_state;
      logic [19:0]        turns_done;
      logic [15:0]        layer_index;
      logic [2:0]         spindle_cmd;
      logic [13:0]        spindle_rpm;
      logic [1:0]         spindle_dir;
      logic [1:0]         traverse_cmd;
      logic [19:0]        traverse_target;
      logic [23:0]        traverse_feed;
      logic [1:0]         radial_cmd;
      logic signed [23:0] radial_target;
   } result_type;

endpackage

/* hw/rtl/cws_feed.sv */
`timescale 1ns / 1ps

// Traverse feed: pitch * speed held in a register, divided by 30 on the
// way out so that a tick right after a speed change sees the new feed.
module cws_feed (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] pitch_next,
   input  logic [13:0] speed_next,
   output logic [23:0] feed
);

   logic [29:0] prod_ff;
   logic [29:0] prod_in;
   logic [60:0] recip_prod;
   logic [25:0] quot;

   assign prod_in = 30'(pitch_next * speed_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= '0;
      end else begin
         prod_ff <= prod_in;
      end
   end

   // Divide by 30 through the reciprocal, then saturate to 24 bits
   assign recip_prod = 61'(prod_ff) * 61'(cws_pkg::FEED_RECIP);
   assign quot       = recip_prod[cws_pkg::FEED_SHIFT +: 26];
   assign feed       = (quot[25:24] != 2'b00) ? 24'hFFFFFF : quot[23:0];

endmodule

/* hw/rtl/cws_step.sv */
`timescale 1ns / 1ps

// One command event: next sequencer state and the axis commands it gives.
module cws_step (
   input  cws_pkg::item_type   item,
   input  cws_pkg::state_type  state,
   input  cws_pkg::cfg_type    cfg,
   input  logic [23:0]         feed,
   output cws_pkg::state_type  state_next,
   output cws_pkg::result_type result
);

   logic [19:0]        cur;
   logic [19:0]        delta;
   logic [20:0]        lt_sum;
   logic [19:0]        lt_sat;
   logic [15:0]        tpl_eff;
   logic [15:0]        step;
   logic signed [24:0] pitch_s;
   logic signed [24:0] pos_sum;
   logic [19:0]        pos_clamp;
   logic signed [24:0] ry_sum;
   logic [23:0]        ry_sat;
   logic               layer_full;

   // Datapath for a tick in the winding state
   always_comb begin
      cur     = item.turn_count & cws_pkg::TURN_MASK;
      delta   = (cur - state.prev_turn) & cws_pkg::TURN_MASK;
      lt_sum  = {1'b0, state.layer_turns} + {1'b0, delta};
      lt_sat  = lt_sum[20] ? 20'hFFFFF : lt_sum[19:0];
      tpl_eff = (cfg.turns_per_layer != 16'd0) ? cfg.turns_per_layer : 16'd1;
      layer_full = (lt_sat >= {4'd0, tpl_eff});

      // traverse target one pitch on, clamped to the bobbin
      pitch_s = $signed({9'd0, cfg.wire_pitch_um});
      pos_sum = state.moving_forward ?
                ($signed({item.trav_meas[23], item.trav_meas}) + pitch_s) :
                ($signed({item.trav_meas[23], item.trav_meas}) - pitch_s);
      if (pos_sum[24]) begin
         pos_clamp = 20'd0;
      end else if (pos_sum[23:0] > {4'd0, cfg.bobbin_width_um}) begin
         pos_clamp = cfg.bobbin_width_um;
      end else begin
         pos_clamp = pos_sum[19:0];
      end

      // radial step outward, saturating at the top of the signed range
      step   = (cfg.layer_step_um != 16'd0) ? cfg.layer_step_um : cfg.wire_pitch_um;
      ry_sum = $signed({item.radial_pos[23], item.radial_pos}) + $signed({9'd0, step});
      ry_sat = (!ry_sum[24] && ry_sum[23]) ? 24'h7FFFFF : ry_sum[23:0];
   end

   // Event decode
   always_comb begin
      state_next = state;
      result                 = '0;
      result.spindle_cmd     = cws_pkg::SP_NONE;
      result.traverse_cmd    = cws_pkg::AX_NONE;
      result.radial_cmd      = cws_pkg::AX_NONE;

      case (cws_pkg::op_type'(item.op))
         cws_pkg::OP_TICK: begin
            if (state.mode == cws_pkg::MODE_WIND) begin
               state_next.turn_latch = cur;
               if (cur >= cfg.turn_limit) begin
                  state_next.mode     = cws_pkg::MODE_DONE;
                  result.spindle_cmd  = cws_pkg::SP_STOP;
                  result.traverse_cmd = cws_pkg::AX_STOP;
               end else if (cur != state.prev_turn) begin
                  state_next.prev_turn   = cur;
                  state_next.layer_turns = lt_sat;
                  result.traverse_cmd    = cws_pkg::AX_MOVE;
                  result.traverse_target = pos_clamp;
                  result.traverse_feed   = feed;
                  if (layer_full) begin
                     if (state.layer_count != 16'hFFFF) begin
                        state_next.layer_count = state.layer_count + 16'd1;
                     end
                     state_next.layer_turns    = 20'd0;
                     state_next.moving_forward = ~state.moving_forward;
                     result.radial_cmd         = cws_pkg::AX_MOVE;
                     result.radial_target      = ry_sat;
                  end
               end
            end
         end
         cws_pkg::OP_START: begin
            if (state.mode == cws_pkg::MODE_IDLE) begin
               state_next.mode           = cws_pkg::MODE_WIND;
               state_next.turn_latch     = 20'd0;
               state_next.layer_count    = 16'd0;
               state_next.layer_turns    = 20'd0;
               state_next.moving_forward = 1'b1;
               state_next.prev_turn      = 20'd0;
               result.spindle_cmd        = cws_pkg::SP_RESTART;
               result.spindle_rpm        = state.speed_setting;
               result.traverse_cmd       = cws_pkg::AX_MOVE;
               result.traverse_feed      = {4'd0, cfg.traverse_max_feed};
            end
         end
         cws_pkg::OP_PAUSE: begin
            if (state.mode == cws_pkg::MODE_WIND) begin
               state_next.mode    = cws_pkg::MODE_PAUSE;
               result.spindle_cmd = cws_pkg::SP_RPM_ZERO;
            end
         end
         cws_pkg::OP_RESUME: begin
            if (state.mode == cws_pkg::MODE_PAUSE) begin
               state_next.mode    = cws_pkg::MODE_WIND;
               result.spindle_cmd = cws_pkg::SP_SET_RPM;
               result.spindle_rpm = state.speed_setting;
            end
         end
         cws_pkg::OP_ABORT: begin
            state_next.mode     = cws_pkg::MODE_IDLE;
            result.spindle_cmd  = cws_pkg::SP_STOP;
            result.traverse_cmd = cws_pkg::AX_STOP;
            result.radial_cmd   = cws_pkg::AX_STOP;
         end
         cws_pkg::OP_SET_SPEED: begin
            state_next.speed_setting = item.new_speed;
            if (state.mode == cws_pkg::MODE_WIND) begin
               result.spindle_cmd = cws_pkg::SP_SET_RPM;
               result.spindle_rpm = item.new_speed;
            end
         end
         default: begin
            // unknown op: nothing happens
         end
      endcase

      result.run_state   = state_next.mode;
      result.turns_done  = state_next.turn_latch;
      result.layer_index = state_next.layer_count;
      result.spindle_dir = cfg.spin_cw ? cws_pkg::DIR_CW : cws_pkg::DIR_CCW;
   end

endmodule

/* hw/rtl/coil_winding_sequencer.sv */
`timescale 1ns / 1ps

// Coil-winding sequencer.
// req_* carries command events (tick, start, pause, resume, abort, set speed);
// rsp_* returns one result per event: run state, turn and layer counters and
// the spindle, traverse and radial axis commands. csr_* writes the program
// registers (pitch, bobbin width, turn totals, feeds, direction), one per cycle,
// and should only be written while no event is in flight.
// A transferred event is held in the input register and worked through the
// step logic, and its result is registered in the output register, which
// drives rsp_tvalid; a stalled output register holds the event where it is.
// Throughput is one event per cycle while the receiver takes results, set by
// the combinational step logic and the traverse feed multiplier behind it.
// When the receiver stalls, the pending result holds and one more event is
// taken into the input register; after that req_tready drops.
// Reset returns the registers to their defaults, the sequencer to idle with
// cleared counters and zero speed, and empties both pipeline registers.
module coil_winding_sequencer (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,  // turn_count, traverse position, radial_pos, new_speed
   input  logic [2:0]   req_tuser,  // op
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,  // run_state, turns_done, layer_index, spindle_cmd,
                                    // spindle_rpm, spindle_dir, traverse_cmd,
                                    // traverse_target, traverse_feed, radial_cmd,
                                    // radial_target
   // configuration writes
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [19:0]  csr_wdata
);

   cws_pkg::cfg_type    cfg_ff, cfg_in;
   cws_pkg::state_type  state_ff, state_in, step_state;
   cws_pkg::item_type   item_ff, item_in;
   cws_pkg::result_type out_ff, out_in, step_result;
   logic                s1_valid_ff, s1_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic                advance, take, fire;
   logic [23:0]         feed;
   logic [13:0]         speed_next;

   // Handshake: the input register moves on whenever the output register is free
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign fire       = s1_valid_ff && advance;

   assign s1_valid_in  = take ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   assign state_in     = fire ? step_state : state_ff;
   assign speed_next   = state_in.speed_setting;

   assign item_in.op         = req_tuser;
   assign item_in.turn_count = req_tdata[19:0];
   assign item_in.trav_meas  = req_tdata[43:20];
   assign item_in.radial_pos = req_tdata[67:44];
   assign item_in.new_speed  = req_tdata[81:68];

   assign out_in = step_result;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cws_pkg::REG_WIRE_PITCH:    cfg_in.wire_pitch_um     = csr_wdata[15:0];
            cws_pkg::REG_BOBBIN_WIDTH:  cfg_in.bobbin_width_um   = csr_wdata;
            cws_pkg::REG_TURN_LIMIT:    cfg_in.turn_limit        = csr_wdata;
            cws_pkg::REG_TURNS_LAYER:   cfg_in.turns_per_layer   = csr_wdata[15:0];
            cws_pkg::REG_LAYER_STEP:    cfg_in.layer_step_um     = csr_wdata[15:0];
            cws_pkg::REG_SPIN_DIR:      cfg_in.spin_cw           = csr_wdata[0];
            cws_pkg::REG_TRAVERSE_FEED: cfg_in.traverse_max_feed = csr_wdata;
            cws_pkg::REG_RADIAL_FEED:   cfg_in.radial_feed       = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Control state, registers and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff.wire_pitch_um     <= 16'd100;
         cfg_ff.bobbin_width_um   <= 20'd10000;
         cfg_ff.turn_limit        <= 20'd100;
         cfg_ff.turns_per_layer   <= 16'd100;
         cfg_ff.layer_step_um     <= 16'd0;
         cfg_ff.spin_cw           <= 1'b1;
         cfg_ff.traverse_max_feed <= 20'd10000;
         cfg_ff.radial_feed       <= 20'd3000;
         state_ff.mode            <= cws_pkg::MODE_IDLE;
         state_ff.prev_turn       <= 20'd0;
         state_ff.layer_turns     <= 20'd0;
         state_ff.layer_count     <= 16'd0;
         state_ff.moving_forward  <= 1'b1;
         state_ff.turn_latch      <= 20'd0;
         state_ff.speed_setting   <= 14'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   cws_feed u_feed (
      .clock      (clock),
      .reset      (reset),
      .pitch_next (cfg_in.wire_pitch_um),
      .speed_next (speed_next),
      .feed       (feed)
   );

   cws_step u_step (
      .item       (item_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .feed       (feed),
      .state_next (step_state),
      .result     (step_result)
   );

   // Result packing, first field in the low bits
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0,
                        out_ff.radial_target,
                        out_ff.radial_cmd,
                        out_ff.traverse_feed,
                        out_ff.traverse_target,
                        out_ff.traverse_cmd,
                        out_ff.spindle_dir,
                        out_ff.spindle_rpm,
                        out_ff.spindle_cmd,
                        out_ff.layer_index,
                        out_ff.turns_done,
                        out_ff.run_state};

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
   import cws_pkg::*;

   // Codes the block does not define; it must ignore them
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 80;
   localparam int RANDOM_PHASES  = 10;
   localparam int SAT_TICKS      = 60;

   typedef struct {
      item_type   item;
      bit         typed;
      result_type res;
   } stim_row;

   typedef struct {
      bit         typed;
      result_type res;
   } sent_note;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [87:0]  req_tdata = '0;  // turn_count, traverse position, radial_pos, new_speed
   logic [2:0]   req_tuser = '0;  // op
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;       // run_state, turns_done, layer_index, spindle_cmd,
                                  // spindle_rpm, spindle_dir, traverse_cmd,
                                  // traverse_target, traverse_feed, radial_cmd,
                                  // radial_target
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [19:0]  csr_wdata = '0;

   coil_winding_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow of the sequencer: program registers and run state
   cfg_type    prog;
   state_type  seq_st;

   result_type rsp_expected_q[$];
   sent_note   sent_note_q[$];
   stim_row    stim_tab[$];

   int  errors = 0;
   int  items_sent = 0;
   int  burst_left = 0;
   bit  req_held = 1'b0;
   int  quiet_cycles = 0;
   int  rx_count = 0;
   int  rx_mode = 0;
   int  rx_hold = 0;
   bit  rx_level = 1'b1;

   // Expected result of one event; updates the shadow state
   function automatic result_type wind_predict(item_type it);
      result_type       r;
      logic [19:0]      cur;
      logic [19:0]      delta;
      logic [20:0]      lsum;
      logic [15:0]      tpl;
      logic [15:0]      rstep;
      longint           pos;
      longint           ry;
      longint unsigned  feed;
      r = '0;
      case (it.op)
         OP_TICK: begin
            if (seq_st.mode == MODE_WIND) begin
               cur = it.turn_count & TURN_MASK;
               seq_st.turn_latch = cur;
               if (cur >= prog.turn_limit) begin
                  seq_st.mode = MODE_DONE;
                  r.spindle_cmd = SP_STOP;
                  r.traverse_cmd = AX_STOP;
               end else if (cur != seq_st.prev_turn) begin
                  delta = (cur - seq_st.prev_turn) & TURN_MASK;
                  tpl = (prog.turns_per_layer != 0) ? prog.turns_per_layer : 16'd1;
                  seq_st.prev_turn = cur;
                  lsum = {1'b0, seq_st.layer_turns} + {1'b0, delta};
                  seq_st.layer_turns = lsum[20] ? 20'hFFFFF : lsum[19:0];
                  // one pitch along the bobbin, clamped to its width
                  pos = $signed(it.trav_meas);
                  if (seq_st.moving_forward)
                     pos = pos + longint'(prog.wire_pitch_um);
                  else
                     pos = pos - longint'(prog.wire_pitch_um);
                  if (pos < 0) pos = 0;
                  if (pos > longint'(prog.bobbin_width_um)) pos = longint'(prog.bobbin_width_um);
                  feed = (longint'(prog.wire_pitch_um) * longint'(seq_st.speed_setting) * 2) / 60;
                  if (feed > 64'hFFFFFF) feed = 64'hFFFFFF;
                  r.traverse_cmd = AX_MOVE;
                  r.traverse_target = pos[19:0];
                  r.traverse_feed = feed[23:0];
                  // layer full: turn round and step outwards
                  if (seq_st.layer_turns >= tpl) begin
                     rstep = (prog.layer_step_um != 0) ? prog.layer_step_um : prog.wire_pitch_um;
                     ry = $signed(it.radial_pos);
                     ry = ry + longint'(rstep);
                     if (ry > 8388607) ry = 8388607;
                     if (seq_st.layer_count != 16'hFFFF) seq_st.layer_count++;
                     seq_st.layer_turns = '0;
                     seq_st.moving_forward = ~seq_st.moving_forward;
                     r.radial_cmd = AX_MOVE;
                     r.radial_target = ry[23:0];
                  end
               end
            end
         end
         OP_START: begin
            if (seq_st.mode == MODE_IDLE) begin
               seq_st.mode = MODE_WIND;
               seq_st.turn_latch = '0;
               seq_st.layer_count = '0;
               seq_st.layer_turns = '0;
               seq_st.moving_forward = 1'b1;
               seq_st.prev_turn = '0;
               r.spindle_cmd = SP_RESTART;
               r.spindle_rpm = seq_st.speed_setting;
               r.traverse_cmd = AX_MOVE;
               r.traverse_feed = {4'd0, prog.traverse_max_feed};
            end
         end
         OP_PAUSE: begin
            if (seq_st.mode == MODE_WIND) begin
               seq_st.mode = MODE_PAUSE;
               r.spindle_cmd = SP_RPM_ZERO;
            end
         end
         OP_RESUME: begin
            if (seq_st.mode == MODE_PAUSE) begin
               seq_st.mode = MODE_WIND;
               r.spindle_cmd = SP_SET_RPM;
               r.spindle_rpm = seq_st.speed_setting;
            end
         end
         OP_ABORT: begin
            seq_st.mode = MODE_IDLE;
            r.spindle_cmd = SP_STOP;
            r.traverse_cmd = AX_STOP;
            r.radial_cmd = AX_STOP;
         end
         OP_SET_SPEED: begin
            seq_st.speed_setting = it.new_speed;
            if (seq_st.mode == MODE_WIND) begin
               r.spindle_cmd = SP_SET_RPM;
               r.spindle_rpm = seq_st.speed_setting;
            end
         end
         default: ;
      endcase
      r.run_state = seq_st.mode;
      r.turns_done = seq_st.turn_latch;
      r.layer_index = seq_st.layer_count;
      r.spindle_dir = prog.spin_cw ? DIR_CW : DIR_CCW;
      return r;
   endfunction

   // Result with cleared counters, for rows whose outcome is plain
   function automatic result_type mk_res(mode_type st, spindle_cmd_type sp, logic [13:0] rpm,
                                          axis_cmd_type tr, logic [23:0] feed,
                                          axis_cmd_type ra);
      result_type r;
      r = '0;
      r.run_state = st;
      r.spindle_cmd = sp;
      r.spindle_rpm = rpm;
      r.spindle_dir = DIR_CW;
      r.traverse_cmd = tr;
      r.traverse_feed = feed;
      r.radial_cmd = ra;
      return r;
   endfunction

   function automatic void add_row(logic [2:0] op, logic [19:0] tc, logic [23:0] tp,
                                   logic [23:0] rp, logic [13:0] spd, bit typed,
                                   result_type res);
      stim_row row;
      row.item.op = op;
      row.item.turn_count = tc;
      row.item.trav_meas = tp;
      row.item.radial_pos = rp;
      row.item.new_speed = spd;
      row.typed = typed;
      row.res = res;
      stim_tab.push_back(row);
   endfunction

   function automatic item_type rand_item();
      item_type it;
      it.op = 3'($urandom_range(0, 7));
      it.turn_count = 20'($urandom);
      it.trav_meas = 24'($urandom);
      it.radial_pos = 24'($urandom);
      it.new_speed = 14'($urandom);
      return it;
   endfunction

   function automatic cfg_type phase_program(int ph);
      cfg_type c;
      case (ph)
         0: begin
            // every register at its lowest value, but pitch and turn limit at one
            c.wire_pitch_um = 16'd1;
            c.bobbin_width_um = '0;
            c.turn_limit = 20'd1;
            c.turns_per_layer = '0;
            c.layer_step_um = '0;
            c.spin_cw = 1'b0;
            c.traverse_max_feed = '0;
            c.radial_feed = '0;
         end
         1: begin
            // every register at its highest value
            c.wire_pitch_um = 16'hFFFF;
            c.bobbin_width_um = 20'hFFFFF;
            c.turn_limit = 20'hFFFFF;
            c.turns_per_layer = 16'hFFFF;
            c.layer_step_um = 16'hFFFF;
            c.spin_cw = 1'b1;
            c.traverse_max_feed = 20'hFFFFF;
            c.radial_feed = 20'hFFFFF;
         end
         default: begin
            c.wire_pitch_um = 16'($urandom_range(1, 65535));
            c.bobbin_width_um = 20'($urandom);
            c.turn_limit = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(1, 1048575))
                                                       : 20'($urandom_range(1, 80));
            c.turns_per_layer = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 10));
            c.layer_step_um = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
            c.spin_cw = 1'($urandom_range(0, 1));
            c.traverse_max_feed = 20'($urandom);
            c.radial_feed = 20'($urandom);
         end
      endcase
      return c;
   endfunction

   task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   // Event transfer: bursts of random length, random gaps between them
   task automatic send_item(item_type it, bit typed, result_type res);
      sent_note note;
      int       gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      note.typed = typed;
      note.res = res;
      sent_note_q.push_back(note);
      req_tvalid <= 1'b1;
      req_held = 1'b1;
      req_tuser <= it.op;
      req_tdata <= {6'd0, it.new_speed, it.radial_pos, it.trav_meas, it.turn_count};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   task automatic send_plain(item_type it);
      send_item(it, 1'b0, '0);
   endtask

   // Let everything in flight come out before touching the registers
   task automatic wait_idle();
      if (req_held) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
      end
      burst_left = 0;
      while (sent_note_q.size() != 0 || rsp_expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [19:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_WIRE_PITCH:    prog.wire_pitch_um = val[15:0];
         REG_BOBBIN_WIDTH:  prog.bobbin_width_um = val;
         REG_TURN_LIMIT:    prog.turn_limit = val;
         REG_TURNS_LAYER:   prog.turns_per_layer = val[15:0];
         REG_LAYER_STEP:    prog.layer_step_um = val[15:0];
         REG_SPIN_DIR:      prog.spin_cw = val[0];
         REG_TRAVERSE_FEED: prog.traverse_max_feed = val;
         REG_RADIAL_FEED:   prog.radial_feed = val;
         default: ;
      endcase
   endtask

   task automatic write_program(cfg_type c);
      write_reg(REG_WIRE_PITCH, {4'd0, c.wire_pitch_um});
      write_reg(REG_BOBBIN_WIDTH, c.bobbin_width_um);
      write_reg(REG_TURN_LIMIT, c.turn_limit);
      write_reg(REG_TURNS_LAYER, {4'd0, c.turns_per_layer});
      write_reg(REG_LAYER_STEP, {4'd0, c.layer_step_um});
      write_reg(REG_SPIN_DIR, {19'd0, c.spin_cw});
      write_reg(REG_TRAVERSE_FEED, c.traverse_max_feed);
      write_reg(REG_RADIAL_FEED, c.radial_feed);
      csr_we <= 1'b0;
   endtask

   // One winding run: start, mostly advancing ticks, with pauses, speed
   // changes, jumps of the turn counter and the odd stray event mixed in
   task automatic wind_session();
      item_type    it;
      logic [19:0] turn;
      int          n;
      int          r;
      if ($urandom_range(0, 1)) begin
         it = rand_item();
         it.op = OP_SET_SPEED;
         send_plain(it);
      end
      if ($urandom_range(0, 4) != 0) begin
         it = rand_item();
         it.op = OP_ABORT;
         send_plain(it);
      end
      it = rand_item();
      it.op = OP_START;
      send_plain(it);
      turn = '0;
      n = $urandom_range(4, 40);
      repeat (n) begin
         r = $urandom_range(0, 99);
         it = rand_item();
         if (r < 80) begin
            // near the top of the counter now and then, so that it wraps
            if ($urandom_range(0, 19) == 0)
               turn = TURN_MASK - 20'($urandom_range(0, 6));
            else
               turn = turn + 20'($urandom_range(0, 3));
            it.op = OP_TICK;
            it.turn_count = turn;
            if ($urandom_range(0, 1))
               it.trav_meas = 24'($urandom % (prog.bobbin_width_um + 1));
         end else if (r < 86) begin
            it.op = OP_PAUSE;
            send_plain(it);
            if ($urandom_range(0, 1)) begin
               it = rand_item();
               it.op = OP_TICK;
               it.turn_count = turn;
               send_plain(it);
            end
            it = rand_item();
            it.op = OP_RESUME;
         end else if (r < 90) begin
            it.op = OP_SET_SPEED;
         end else if (r < 93) begin
            // counter jumps anywhere, backwards included
            it.op = OP_TICK;
            turn = it.turn_count;
         end else if (r < 96) begin
            // stray event with a random code
         end else if (r < 98) begin
            it.op = OP_ABORT;
         end else begin
            it.op = OP_START;
         end
         send_plain(it);
      end
   endtask

   // Receiver back-pressure in one of four patterns, picked at random by a running cycle count
   always @(posedge clock) begin
      rx_count++;
      if (rx_count % 256 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 9) < 7);
         2: rsp_tready <= (rx_count % 4 == 0);
         default: begin
            if (rx_hold == 0) begin
               rx_hold = $urandom_range(1, 12);
               rx_level = ~rx_level;
            end
            rx_hold--;
            rsp_tready <= rx_level;
         end
      endcase
   end

   // Predict on each event transfer, check on each result transfer
   always @(posedge clock) begin
      item_type   acc;
      result_type want;
      result_type got;
      sent_note   note;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            acc.op = req_tuser;
            acc.turn_count = req_tdata[19:0];
            acc.trav_meas = req_tdata[43:20];
            acc.radial_pos = req_tdata[67:44];
            acc.new_speed = req_tdata[81:68];
            want = wind_predict(acc);
            if (sent_note_q.size() != 0) begin
               note = sent_note_q.pop_front();
               if (note.typed) want = note.res;
            end
            rsp_expected_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.run_state = rsp_tdata[1:0];
            got.turns_done = rsp_tdata[21:2];
            got.layer_index = rsp_tdata[37:22];
            got.spindle_cmd = rsp_tdata[40:38];
            got.spindle_rpm = rsp_tdata[54:41];
            got.spindle_dir = rsp_tdata[56:55];
            got.traverse_cmd = rsp_tdata[58:57];
            got.traverse_target = rsp_tdata[78:59];
            got.traverse_feed = rsp_tdata[102:79];
            got.radial_cmd = rsp_tdata[104:103];
            got.radial_target = rsp_tdata[128:105];
            if (rsp_expected_q.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, got 0x%0h", $time, rsp_tdata);
            end else begin
               want = rsp_expected_q.pop_front();
               check_field("run_state", 24'(want.run_state), 24'(got.run_state));
               check_field("turns_done", 24'(want.turns_done), 24'(got.turns_done));
               check_field("layer_index", 24'(want.layer_index), 24'(got.layer_index));
               check_field("spindle_cmd", 24'(want.spindle_cmd), 24'(got.spindle_cmd));
               check_field("spindle_rpm", 24'(want.spindle_rpm), 24'(got.spindle_rpm));
               check_field("spindle_dir", 24'(want.spindle_dir), 24'(got.spindle_dir));
               check_field("traverse_cmd", 24'(want.traverse_cmd), 24'(got.traverse_cmd));
               check_field("traverse_target", 24'(want.traverse_target),
                           24'(got.traverse_target));
               check_field("traverse_feed", want.traverse_feed, got.traverse_feed);
               check_field("radial_cmd", 24'(want.radial_cmd), 24'(got.radial_cmd));
               check_field("radial_target", want.radial_target, got.radial_target);
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      result_type quiet_res;
      cfg_type    sat_cfg;
      item_type   it;
      int         ph_start;

      // register defaults and run state after reset
      prog.wire_pitch_um = 16'd100;
      prog.bobbin_width_um = 20'd10000;
      prog.turn_limit = 20'd100;
      prog.turns_per_layer = 16'd100;
      prog.layer_step_um = '0;
      prog.spin_cw = 1'b1;
      prog.traverse_max_feed = 20'd10000;
      prog.radial_feed = 20'd3000;
      seq_st = '0;
      seq_st.mode = MODE_IDLE;
      seq_st.moving_forward = 1'b1;

      // Directed events against the reset program
      quiet_res = mk_res(MODE_IDLE, SP_NONE, 14'd0, AX_NONE, 24'd0, AX_NONE);
      // tick, pause, resume and unknown codes in idle do nothing
      add_row(OP_TICK, 20'hFFFFF, 24'h7FFFFF, 24'h800000, 14'h3FFF, 1'b1, quiet_res);
      add_row(OP_PAUSE, 20'h0, 24'h0, 24'h0, 14'h0, 1'b1, quiet_res);
      add_row(OP_RESUME, 20'h0, 24'h800000, 24'h7FFFFF, 14'h0, 1'b1, quiet_res);
      add_row(OP_UNUSED_6, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF, 14'h3FFF, 1'b1, quiet_res);
      add_row(OP_UNUSED_7, 20'h0, 24'h0, 24'h0, 14'h0, 1'b1, quiet_res);
      // abort is honoured in every state
      add_row(OP_ABORT, 20'h0, 24'h0, 24'h0, 14'h0, 1'b1,
              mk_res(MODE_IDLE, SP_STOP, 14'd0, AX_STOP, 24'd0, AX_STOP));
      // speed while idle: stored, no command
      add_row(OP_SET_SPEED, 20'h0, 24'h0, 24'h0, 14'h3FFF, 1'b1, quiet_res);
      add_row(OP_START, 20'hFFFFF, 24'h7FFFFF, 24'h7FFFFF, 14'h0, 1'b1,
              mk_res(MODE_WIND, SP_RESTART, 14'h3FFF, AX_MOVE, 24'd10000, AX_NONE));
      // second start while winding is ignored
      add_row(OP_START, 20'h0, 24'h0, 24'h0, 14'h0, 1'b1,
              mk_res(MODE_WIND, SP_NONE, 14'd0, AX_NONE, 24'd0, AX_NONE));
      // traverse clamp below zero and above the bobbin, repeated turn
      add_row(OP_TICK, 20'd1, 24'h800000, 24'h0, 14'h0, 1'b0, '0);
      add_row(OP_TICK, 20'd2, 24'h7FFFFF, 24'h0, 14'h0, 1'b0, '0);
      add_row(OP_TICK, 20'd2, 24'd500, 24'h0, 14'h0, 1'b0, '0);
      // counter runs backwards: huge delta fills the layer, radial saturates
      add_row(OP_TICK, 20'd1, 24'd500, 24'h7FFFFF, 14'h0, 1'b0, '0);
      add_row(OP_TICK, 20'd5, 24'd50, 24'h800000, 14'h0, 1'b0, '0);
      add_row(OP_PAUSE, 20'h0, 24'h0, 24'h0, 14'h0, 1'b0, '0);
      add_row(OP_TICK, 20'd9, 24'd50, 24'h0, 14'h0, 1'b0, '0);
      add_row(OP_SET_SPEED, 20'h0, 24'h0, 24'h0, 14'h0, 1'b0, '0);
      add_row(OP_RESUME, 20'h0, 24'h0, 24'h0, 14'h0, 1'b0, '0);
      add_row(OP_SET_SPEED, 20'h0, 24'h0, 24'h0, 14'd1234, 1'b0, '0);
      // total reached
      add_row(OP_TICK, 20'd100, 24'd50, 24'h0, 14'h0, 1'b0, '0);
      add_row(OP_TICK, 20'd3, 24'd50, 24'h0, 14'h0, 1'b0, '0);
      add_row(OP_START, 20'h0, 24'h0, 24'h0, 14'h0, 1'b0, '0);
      add_row(OP_PAUSE, 20'h0, 24'h0, 24'h0, 14'h0, 1'b0, '0);
      add_row(OP_ABORT, 20'h0, 24'h0, 24'h0, 14'h0, 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_tab[i]) send_item(stim_tab[i].item, stim_tab[i].typed, stim_tab[i].res);

      // Random runs under a new program per phase, extremes first
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         write_program(phase_program(ph));
         ph_start = items_sent;
         while (items_sent - ph_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
               wind_session();
            end else begin
               it = rand_item();
               send_plain(it);
            end
         end
      end

      // A short run with turns per layer of zero, which acts as one:
      // a new layer on every turn
      wait_idle();
      sat_cfg.wire_pitch_um = 16'd1;
      sat_cfg.bobbin_width_um = 20'hFFFFF;
      sat_cfg.turn_limit = 20'hFFFFF;
      sat_cfg.turns_per_layer = '0;
      sat_cfg.layer_step_um = 16'($urandom);
      sat_cfg.spin_cw = 1'($urandom_range(0, 1));
      sat_cfg.traverse_max_feed = 20'($urandom);
      sat_cfg.radial_feed = 20'($urandom);
      write_program(sat_cfg);
      it = rand_item();
      it.op = OP_ABORT;
      send_plain(it);
      it = rand_item();
      it.op = OP_SET_SPEED;
      send_plain(it);
      it = rand_item();
      it.op = OP_START;
      send_plain(it);
      for (int t = 1; t <= SAT_TICKS; t++) begin
         it = rand_item();
         it.op = OP_TICK;
         it.turn_count = 20'(t);
         send_plain(it);
      end

      wait_idle();
      if (errors == 0 && rsp_expected_q.size() == 0 && sent_note_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
